[src/sgc_pkg.sv]
// Package for the sky gradient cube-map texel unit.
// Register indexes, reset values, field widths, face codes and other constants.
// No dependencies.
`timescale 1ns / 1ps

package sgc_pkg;

   localparam int MAX_SIDE = 1024;
   localparam int SIDE_W   = 11;
   localparam int COLOR_W  = 8;
   localparam int FACE_W   = 3;
   localparam int COORD_W  = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] REG_SIDE_LENGTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ZENITH_RED   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ZENITH_GREEN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ZENITH_BLUE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NADIR_RED    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NADIR_GREEN  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_NADIR_BLUE   = 3'd6;

   localparam logic [SIDE_W-1:0]  RST_SIDE_LENGTH  = 11'd256;
   localparam logic [COLOR_W-1:0] RST_ZENITH_RED   = 8'd160;
   localparam logic [COLOR_W-1:0] RST_ZENITH_GREEN = 8'd190;
   localparam logic [COLOR_W-1:0] RST_ZENITH_BLUE  = 8'd225;
   localparam logic [COLOR_W-1:0] RST_NADIR_RED    = 8'd30;
   localparam logic [COLOR_W-1:0] RST_NADIR_GREEN  = 8'd30;
   localparam logic [COLOR_W-1:0] RST_NADIR_BLUE   = 8'd40;
   localparam logic [COLOR_W-1:0] ALPHA_OPAQUE     = 8'd255;

   localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;

endpackage

[src/sgc_div_pipe.sv]
// Pipelined restoring divider, a few quotient bits per stage, with sideband.
// Requires num >> Q_W < den. No package dependencies.
`timescale 1ns / 1ps

module sgc_div_pipe #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 11,
   parameter int Q_W   = 18,
   parameter int BPS   = 3,
   parameter int SB_W  = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [SB_W-1:0]  in_sb,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_quo,
   output logic [SB_W-1:0]  out_sb
);

   localparam int STAGES = (Q_W + BPS - 1) / BPS;

   logic [DEN_W-1:0] rem_ff   [STAGES];
   logic [Q_W-1:0]   lo_ff    [STAGES];
   logic [Q_W-1:0]   quo_ff   [STAGES];
   logic [DEN_W-1:0] den_ff   [STAGES];
   logic [SB_W-1:0]  sb_ff    [STAGES];
   logic             valid_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [DEN_W-1:0] rem_src, den_src, rem_in;
      logic [Q_W-1:0]   lo_src, quo_src, lo_in, quo_in;
      logic [SB_W-1:0]  sb_src;
      logic             v_src;

      if (s == 0) begin : g_first
         assign rem_src = DEN_W'(in_num >> Q_W);
         assign lo_src  = in_num[Q_W-1:0];
         assign quo_src = '0;
         assign den_src = in_den;
         assign sb_src  = in_sb;
         assign v_src   = in_valid;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign lo_src  = lo_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign den_src = den_ff[s-1];
         assign sb_src  = sb_ff[s-1];
         assign v_src   = valid_ff[s-1];
      end

      always_comb begin
         logic [DEN_W:0] t;
         rem_in = rem_src;
         lo_in  = lo_src;
         quo_in = quo_src;
         for (int j = 0; j < BPS; j++) begin
            if (s * BPS + j < Q_W) begin
               t     = {rem_in, lo_in[Q_W-1]};
               lo_in = lo_in << 1;
               if (t >= {1'b0, den_src}) begin
                  t      = t - {1'b0, den_src};
                  quo_in = (quo_in << 1) | Q_W'(1);
               end else begin
                  quo_in = quo_in << 1;
               end
               rem_in = t[DEN_W-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            lo_ff[s]  <= lo_in;
            quo_ff[s] <= quo_in;
            den_ff[s] <= den_src;
            sb_ff[s]  <= sb_src;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_quo   = quo_ff[STAGES-1];
   assign out_sb    = sb_ff[STAGES-1];

endmodule

[src/sgc_sqrt_pipe.sv]
// Pipelined digit-by-digit integer square root (floor), a few root bits per stage.
// Carries a sideband word alongside. No package dependencies.
`timescale 1ns / 1ps

module sgc_sqrt_pipe #(
   parameter int X_W  = 34,
   parameter int BPS  = 2,
   parameter int SB_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [X_W-1:0]     in_x,
   input  logic [SB_W-1:0]    in_sb,
   output logic               out_valid,
   output logic [X_W/2-1:0]   out_root,
   output logic [SB_W-1:0]    out_sb
);

   localparam int R_W    = X_W / 2;
   localparam int REM_W  = R_W + 3;
   localparam int STAGES = (R_W + BPS - 1) / BPS;

   logic [REM_W-1:0] rem_ff   [STAGES];
   logic [R_W-1:0]   root_ff  [STAGES];
   logic [X_W-1:0]   xs_ff    [STAGES];
   logic [SB_W-1:0]  sb_ff    [STAGES];
   logic             valid_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [REM_W-1:0] rem_src, rem_in;
      logic [R_W-1:0]   root_src, root_in;
      logic [X_W-1:0]   xs_src, xs_in;
      logic [SB_W-1:0]  sb_src;
      logic             v_src;

      if (s == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign xs_src   = in_x;
         assign sb_src   = in_sb;
         assign v_src    = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
         assign xs_src   = xs_ff[s-1];
         assign sb_src   = sb_ff[s-1];
         assign v_src    = valid_ff[s-1];
      end

      always_comb begin
         logic [REM_W-1:0] t, trial;
         rem_in  = rem_src;
         root_in = root_src;
         xs_in   = xs_src;
         for (int j = 0; j < BPS; j++) begin
            if (s * BPS + j < R_W) begin
               t     = {rem_in[REM_W-3:0], xs_in[X_W-1:X_W-2]};
               xs_in = xs_in << 2;
               trial = REM_W'({root_in, 2'b01});
               if (t >= trial) begin
                  rem_in  = t - trial;
                  root_in = (root_in << 1) | R_W'(1);
               end else begin
                  rem_in  = t;
                  root_in = root_in << 1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            xs_ff[s]   <= xs_in;
            sb_ff[s]   <= sb_src;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_sb    = sb_ff[STAGES-1];

endmodule

[src/sky_gradient_cubemap_texel_unit.sv]
// Top level of the sky gradient cube-map texel unit.
// Depends on sgc_pkg, sgc_div_pipe and sgc_sqrt_pipe.
`timescale 1ns / 1ps

// Takes one texel (face, column, row) per transaction and returns its RGBA sky
// color. The pipeline accepts a new transaction every clock unless back pressure
// holds it. It has an input register, a 6-stage coordinate divider, coordinate,
// square and length stages, a 9-stage square root, a 6-stage reciprocal divider
// and four blend and output stages. Back pressure on rsp_tready holds the whole
// pipeline in place. Configuration is written through csr_we/csr_index/csr_wdata
// while no transaction is in flight; the block itself does not enforce this.
module sky_gradient_cubemap_texel_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // face[2:0], column[12:3], row[22:13]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
   input  logic        csr_we,
   input  logic [sgc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sgc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [10:0] side_ff;
   logic [7:0]  zr_ff, zg_ff, zb_ff, nr_ff, ng_ff, nb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= sgc_pkg::RST_SIDE_LENGTH;
         zr_ff   <= sgc_pkg::RST_ZENITH_RED;
         zg_ff   <= sgc_pkg::RST_ZENITH_GREEN;
         zb_ff   <= sgc_pkg::RST_ZENITH_BLUE;
         nr_ff   <= sgc_pkg::RST_NADIR_RED;
         ng_ff   <= sgc_pkg::RST_NADIR_GREEN;
         nb_ff   <= sgc_pkg::RST_NADIR_BLUE;
      end else if (csr_we) begin
         unique case (csr_index)
            sgc_pkg::REG_SIDE_LENGTH:  side_ff <= csr_wdata;
            sgc_pkg::REG_ZENITH_RED:   zr_ff   <= csr_wdata[7:0];
            sgc_pkg::REG_ZENITH_GREEN: zg_ff   <= csr_wdata[7:0];
            sgc_pkg::REG_ZENITH_BLUE:  zb_ff   <= csr_wdata[7:0];
            sgc_pkg::REG_NADIR_RED:    nr_ff   <= csr_wdata[7:0];
            sgc_pkg::REG_NADIR_GREEN:  ng_ff   <= csr_wdata[7:0];
            sgc_pkg::REG_NADIR_BLUE:   nb_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic out_v_ff;
   assign adv        = !out_v_ff || rsp_tready;
   assign req_tready = adv;

   // side clamp
   logic [10:0] side_eff;
   always_comb begin
      if (side_ff == 11'd0) begin
         side_eff = 11'd1;
      end else if ({6'd0, side_ff} > 17'(sgc_pkg::MAX_SIDE)) begin
         side_eff = 11'(sgc_pkg::MAX_SIDE);
      end else begin
         side_eff = side_ff;
      end
   end

   // stage A: input register
   logic        a_v_ff;
   logic [2:0]  a_face_ff;
   logic [9:0]  a_col_ff, a_row_ff;
   logic [10:0] a_side_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= req_tvalid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         a_face_ff <= req_tdata[2:0];
         a_col_ff  <= req_tdata[12:3];
         a_row_ff  <= req_tdata[22:13];
         a_side_ff <= side_eff;
      end
   end

   logic a_ucap, a_vcap;
   assign a_ucap = {1'b0, a_col_ff} >= a_side_ff;
   assign a_vcap = {1'b0, a_row_ff} >= a_side_ff;

   logic        du_v, dv_v;
   logic [17:0] du_q, dv_q;
   logic [3:0]  du_sb;
   logic        dv_sb;

   sgc_div_pipe #(.NUM_W(27), .DEN_W(11), .Q_W(18), .BPS(3), .SB_W(4)) u_div_u (
      .clock(clock), .reset(reset), .en(adv), .in_valid(a_v_ff),
      .in_num({a_col_ff, 1'b1, 16'd0}), .in_den(a_side_ff), .in_sb({a_face_ff, a_ucap}),
      .out_valid(du_v), .out_quo(du_q), .out_sb(du_sb)
   );

   sgc_div_pipe #(.NUM_W(27), .DEN_W(11), .Q_W(18), .BPS(3), .SB_W(1)) u_div_v (
      .clock(clock), .reset(reset), .en(adv), .in_valid(a_v_ff),
      .in_num({a_row_ff, 1'b1, 16'd0}), .in_den(a_side_ff), .in_sb(a_vcap),
      .out_valid(dv_v), .out_quo(dv_q), .out_sb(dv_sb)
   );

   // stage B: coordinates and up component
   logic signed [17:0] u_in, v_in, up_in;
   assign u_in = du_sb[0] ? 18'sd65536 : $signed(du_q - 18'd65536);
   assign v_in = dv_sb ? 18'sd65536 : $signed(dv_q - 18'd65536);
   always_comb begin
      if (du_sb[3:1] == sgc_pkg::FACE_POS_Y) begin
         up_in = 18'sd65536;
      end else if (du_sb[3:1] == sgc_pkg::FACE_NEG_Y) begin
         up_in = -18'sd65536;
      end else begin
         up_in = -v_in;
      end
   end

   logic               b_v_ff;
   logic signed [17:0] b_u_ff, b_v2_ff, b_up_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (adv) begin
         b_v_ff <= du_v;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         b_u_ff  <= u_in;
         b_v2_ff <= v_in;
         b_up_ff <= up_in;
      end
   end

   // stage C: squares
   logic signed [35:0] usq, vsq;
   assign usq = b_u_ff * b_u_ff;
   assign vsq = b_v2_ff * b_v2_ff;

   logic               c_v_ff;
   logic [32:0]        c_usq_ff, c_vsq_ff;
   logic signed [17:0] c_up_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (adv) begin
         c_v_ff <= b_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         c_usq_ff <= usq[32:0];
         c_vsq_ff <= vsq[32:0];
         c_up_ff  <= b_up_ff;
      end
   end

   // stage D: squared length
   logic               d_v_ff;
   logic [33:0]        d_len2_ff;
   logic signed [17:0] d_up_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (adv) begin
         d_v_ff <= c_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         d_len2_ff <= 34'h1_0000_0000 + {1'b0, c_usq_ff} + {1'b0, c_vsq_ff};
         d_up_ff   <= c_up_ff;
      end
   end

   logic        sq_v;
   logic [16:0] sq_root;
   logic [17:0] sq_sb;
   sgc_sqrt_pipe #(.X_W(34), .BPS(2), .SB_W(18)) u_sqrt (
      .clock(clock), .reset(reset), .en(adv), .in_valid(d_v_ff),
      .in_x(d_len2_ff), .in_sb(d_up_ff),
      .out_valid(sq_v), .out_root(sq_root), .out_sb(sq_sb)
   );

   logic        rc_v;
   logic [16:0] rc_q;
   logic [17:0] rc_sb;
   sgc_div_pipe #(.NUM_W(33), .DEN_W(17), .Q_W(17), .BPS(3), .SB_W(18)) u_recip (
      .clock(clock), .reset(reset), .en(adv), .in_valid(sq_v),
      .in_num(33'h1_0000_0000), .in_den(sq_root), .in_sb(sq_sb),
      .out_valid(rc_v), .out_quo(rc_q), .out_sb(rc_sb)
   );

   // stage E: magnitude of height
   logic [15:0]        recip;
   logic signed [17:0] rc_up, rc_nup;
   logic [16:0]        abs_up;
   logic [32:0]        mag_prod;
   assign recip    = rc_q[16] ? 16'hFFFF : rc_q[15:0];
   assign rc_up    = $signed(rc_sb);
   assign rc_nup   = -rc_up;
   assign abs_up   = rc_up[17] ? rc_nup[16:0] : rc_up[16:0];
   assign mag_prod = abs_up * recip;

   logic        e_v_ff, e_neg_ff;
   logic [16:0] e_mag_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (adv) begin
         e_v_ff <= rc_v;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         e_mag_ff <= mag_prod[32:16];
         e_neg_ff <= rc_up[17];
      end
   end

   // stage F: blend
   logic signed [17:0] height, bsum;
   assign height = e_neg_ff ? -$signed({1'b0, e_mag_ff}) : $signed({1'b0, e_mag_ff});
   assign bsum   = height + 18'sd65536;

   logic        f_v_ff;
   logic [15:0] f_blend_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (adv) begin
         f_v_ff <= e_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         f_blend_ff <= bsum[16:1];
      end
   end

   // stage G: channel products
   logic signed [16:0] blend_s;
   logic signed [8:0]  dr, dg, db;
   assign blend_s = $signed({1'b0, f_blend_ff});
   assign dr = $signed({1'b0, zr_ff}) - $signed({1'b0, nr_ff});
   assign dg = $signed({1'b0, zg_ff}) - $signed({1'b0, ng_ff});
   assign db = $signed({1'b0, zb_ff}) - $signed({1'b0, nb_ff});

   logic               g_v_ff;
   logic signed [25:0] g_pr_ff, g_pg_ff, g_pb_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else if (adv) begin
         g_v_ff <= f_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         g_pr_ff <= dr * blend_s;
         g_pg_ff <= dg * blend_s;
         g_pb_ff <= db * blend_s;
      end
   end

   // stage H: output register
   logic signed [25:0] tr, tg, tb;
   assign tr = $signed({2'b00, nr_ff, 16'd0}) + g_pr_ff;
   assign tg = $signed({2'b00, ng_ff, 16'd0}) + g_pg_ff;
   assign tb = $signed({2'b00, nb_ff, 16'd0}) + g_pb_ff;

   logic [31:0] out_data_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= g_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= {sgc_pkg::ALPHA_OPAQUE, tb[23:16], tg[23:16], tr[23:16]};
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      du_v == dv_v)
      else $error("coordinate dividers out of step");

   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:24] == sgc_pkg::ALPHA_OPAQUE)
      else $error("alpha not opaque");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

[bench/tb_sky_gradient_cubemap_texel_unit.sv]
// Testbench for sky_gradient_cubemap_texel_unit: drives texel transactions with random
// gaps and back pressure, predicts each RGBA result in fixed point and checks it in order.
// Depends on sgc_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_sky_gradient_cubemap_texel_unit;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } texel_color_type;

   typedef struct {
      logic [sgc_pkg::FACE_W-1:0]  face;
      logic [sgc_pkg::COORD_W-1:0] col;
      logic [sgc_pkg::COORD_W-1:0] row;
      bit                          typed;
      logic [7:0]                  red;
      logic [7:0]                  green;
      logic [7:0]                  blue;
   } stim_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 0;
   logic [sgc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [sgc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   logic [sgc_pkg::SIDE_W-1:0]  side_reg = sgc_pkg::RST_SIDE_LENGTH;
   logic [sgc_pkg::COLOR_W-1:0] zen_r = sgc_pkg::RST_ZENITH_RED;
   logic [sgc_pkg::COLOR_W-1:0] zen_g = sgc_pkg::RST_ZENITH_GREEN;
   logic [sgc_pkg::COLOR_W-1:0] zen_b = sgc_pkg::RST_ZENITH_BLUE;
   logic [sgc_pkg::COLOR_W-1:0] nad_r = sgc_pkg::RST_NADIR_RED;
   logic [sgc_pkg::COLOR_W-1:0] nad_g = sgc_pkg::RST_NADIR_GREEN;
   logic [sgc_pkg::COLOR_W-1:0] nad_b = sgc_pkg::RST_NADIR_BLUE;

   logic [sgc_pkg::CSR_IDX_W-1:0] color_regs[6] = '{
      sgc_pkg::REG_ZENITH_RED, sgc_pkg::REG_ZENITH_GREEN, sgc_pkg::REG_ZENITH_BLUE,
      sgc_pkg::REG_NADIR_RED, sgc_pkg::REG_NADIR_GREEN, sgc_pkg::REG_NADIR_BLUE
   };

   texel_color_type color_q[$];
   int  errors = 0;
   bit  no_idle = 0;
   int  hold_cycles = 0;

   stim_row_type dir_tab[14];

   sky_gradient_cubemap_texel_unit dut (.*);

   always #1 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint texel_coord(int unsigned c, int unsigned side);
      longint t;
      t = longint'(((64'(2 * c + 1)) << 16) / side) - 65536;
      if (t > 65536) t = 65536;
      return t;
   endfunction

   function automatic logic [7:0] blend_channel(logic [7:0] nad, logic [7:0] zen, longint bl);
      longint total;
      total = longint'(nad) * 65536 + (longint'(zen) - longint'(nad)) * bl;
      if (total < 0) total = 0;
      return 8'(total >>> 16);
   endfunction

   function automatic texel_color_type sky_color(logic [2:0] face, logic [9:0] col,
                                                 logic [9:0] row);
      int unsigned side;
      longint u, v, up, mag, height, bl;
      longint unsigned len2, s, r, aup;
      texel_color_type c;
      side = side_reg;
      if (side == 0) side = 1;
      if (side > sgc_pkg::MAX_SIDE) side = sgc_pkg::MAX_SIDE;
      u = texel_coord(col, side);
      v = texel_coord(row, side);
      if (face == sgc_pkg::FACE_POS_Y) up = 65536;
      else if (face == sgc_pkg::FACE_NEG_Y) up = -65536;
      else up = -v;
      len2 = (64'd1 << 32) + 64'(u * u) + 64'(v * v);
      s = int_sqrt(len2);
      r = (64'd1 << 32) / s;
      if (r > 65535) r = 65535;
      aup = (up < 0) ? 64'(-up) : 64'(up);
      mag = longint'((aup * r) >> 16);
      height = (up < 0) ? -mag : mag;
      bl = (height + 65536) / 2;
      c.red   = blend_channel(nad_r, zen_r, bl);
      c.green = blend_channel(nad_g, zen_g, bl);
      c.blue  = blend_channel(nad_b, zen_b, bl);
      c.alpha = sgc_pkg::ALPHA_OPAQUE;
      return c;
   endfunction

   task automatic send_texel(logic [2:0] face, logic [9:0] col, logic [9:0] row,
                             bit typed, texel_color_type typed_color);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, row, col, face};
      do @(posedge clock); while (!req_tready);
      color_q.push_back(typed ? typed_color : sky_color(face, col, row));
   endtask

   task automatic write_reg(logic [sgc_pkg::CSR_IDX_W-1:0] idx,
                            logic [sgc_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         sgc_pkg::REG_SIDE_LENGTH:  side_reg = val;
         sgc_pkg::REG_ZENITH_RED:   zen_r = val[7:0];
         sgc_pkg::REG_ZENITH_GREEN: zen_g = val[7:0];
         sgc_pkg::REG_ZENITH_BLUE:  zen_b = val[7:0];
         sgc_pkg::REG_NADIR_RED:    nad_r = val[7:0];
         sgc_pkg::REG_NADIR_GREEN:  nad_g = val[7:0];
         sgc_pkg::REG_NADIR_BLUE:   nad_b = val[7:0];
         default: ;
      endcase
   endtask

   task automatic drain_idle();
      req_tvalid <= 1'b0;
      while (color_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_texels(int count, int unsigned side);
      int unsigned lim;
      logic [2:0] face;
      logic [9:0] col, row;
      lim = (side == 0) ? 1 : ((side > sgc_pkg::MAX_SIDE) ? sgc_pkg::MAX_SIDE : side);
      for (int i = 0; i < count; i++) begin
         face = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
         if ($urandom_range(0, 9) == 0) begin
            col = 10'($urandom);
            row = 10'($urandom);
         end else begin
            col = 10'($urandom_range(0, lim - 1));
            row = 10'($urandom_range(0, lim - 1));
         end
         send_texel(face, col, row, 1'b0, '0);
      end
   endtask

   always begin
      int gap;
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         repeat (hold_cycles) @(posedge clock);
         hold_cycles = 0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         rsp_tready <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      rsp_tready <= 1'b1;
      do @(posedge clock); while (rsp_tvalid !== 1'b1);
      if (color_q.size() == 0) begin
         $error("unexpected transaction: %h", rsp_tdata);
         errors++;
      end else begin
         texel_color_type e, a;
         e = color_q.pop_front();
         a = '{rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tdata[31:24]};
         if (a.red !== e.red) begin
            $error("red: expected %0d actual %0d", e.red, a.red); errors++;
         end
         if (a.green !== e.green) begin
            $error("green: expected %0d actual %0d", e.green, a.green); errors++;
         end
         if (a.blue !== e.blue) begin
            $error("blue: expected %0d actual %0d", e.blue, a.blue); errors++;
         end
         if (a.alpha !== e.alpha) begin
            $error("alpha: expected %0d actual %0d", e.alpha, a.alpha); errors++;
         end
      end
   end

   initial begin
      #200000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int unsigned sides[9];
      texel_color_type tc;
      sides = '{256, 1, 0, 2047, 1024, 3, 2, 7, 0};
      // side 1, reset colors: center texel gives zenith-1, nadir, or the midpoint; other rows are predicted
      dir_tab = '{
         '{3'd2, 10'd0, 10'd0, 1'b1, 8'd159, 8'd189, 8'd224},
         '{3'd3, 10'd0, 10'd0, 1'b1, 8'd30, 8'd30, 8'd40},
         '{3'd0, 10'd0, 10'd0, 1'b1, 8'd95, 8'd110, 8'd132},
         '{3'd1, 10'd0, 10'd0, 1'b1, 8'd95, 8'd110, 8'd132},
         '{3'd4, 10'd0, 10'd0, 1'b1, 8'd95, 8'd110, 8'd132},
         '{3'd5, 10'd0, 10'd0, 1'b1, 8'd95, 8'd110, 8'd132},
         '{3'd6, 10'd0, 10'd0, 1'b1, 8'd95, 8'd110, 8'd132},
         '{3'd7, 10'd0, 10'd0, 1'b1, 8'd95, 8'd110, 8'd132},
         '{3'd0, 10'd1023, 10'd1023, 1'b0, 0, 0, 0},
         '{3'd2, 10'd1023, 10'd0, 1'b0, 0, 0, 0},
         '{3'd3, 10'd0, 10'd1023, 1'b0, 0, 0, 0},
         '{3'd4, 10'd5, 10'd1, 1'b0, 0, 0, 0},
         '{3'd1, 10'd682, 10'd341, 1'b0, 0, 0, 0},
         '{3'd7, 10'd1023, 10'd1023, 1'b0, 0, 0, 0}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      random_texels(10, 256);
      drain_idle();
      write_reg(sgc_pkg::REG_SIDE_LENGTH, 11'd1);
      csr_we <= 1'b0;
      foreach (dir_tab[i]) begin
         tc = '{dir_tab[i].red, dir_tab[i].green, dir_tab[i].blue, sgc_pkg::ALPHA_OPAQUE};
         send_texel(dir_tab[i].face, dir_tab[i].col, dir_tab[i].row, dir_tab[i].typed, tc);
      end

      foreach (sides[p]) begin
         drain_idle();
         write_reg(sgc_pkg::REG_SIDE_LENGTH,
                   (p == 8) ? 11'($urandom_range(1, 64)) : 11'(sides[p]));
         for (int k = 0; k < 6; k++) begin
            logic [7:0] cv;
            case ($urandom_range(0, 3))
               0: cv = 8'd0;
               1: cv = 8'd255;
               default: cv = 8'($urandom);
            endcase
            write_reg(color_regs[k], {3'b0, cv});
         end
         csr_we <= 1'b0;
         no_idle = (p % 3 == 1);
         if (p == 4) hold_cycles = 300;
         random_texels(24, side_reg);
         if (p == 2) begin
            req_tvalid <= 1'b0;
            while (color_q.size() != 0) @(posedge clock);
         end
         random_texels(24, side_reg);
      end
      no_idle = 0;
      drain_idle();
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
